// ===== design/trmc_pkg.sv =====
// Shared constants, codes and types of the table row mismatch counter.
`default_nettype none
package trmc_pkg;

    // Table geometry and stored value width
    localparam int ROWS        = 16;
    localparam int COLS        = 8;
    localparam int VALUE_WIDTH = 32;

    // Fixed field widths of the request and result channels
    localparam int OP_W    = 2;
    localparam int ROW_W   = 4;
    localparam int COL_W   = 3;
    localparam int VAL_W   = 32;
    localparam int MIS_W   = 4;
    localparam int CFG_R_W = 5;
    localparam int CFG_C_W = 4;
    localparam int CFG_D_W = 5;

    // Derived internal widths
    localparam int ROW_IW = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_IW = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int NR_W   = $clog2(ROWS + 1);
    localparam int CNT_W  = $clog2(COLS + 1);

    // Request queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Operation codes
    localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
    localparam logic [OP_W-1:0] OP_SET    = 2'd1;
    localparam logic [OP_W-1:0] OP_RECOMP = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // Configuration register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // One queued request
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [VAL_W-1:0] value;
    } t_item;

endpackage
`default_nettype wire

// ===== design/table_row_mismatch_counter.sv =====
// Top level of the table row mismatch counter: configuration registers and the two halves.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+------------------------------------------
//  request  | i_valid / o_ready          | i_op, i_row, i_col, i_value
//  result   | o_valid / i_ready          | o_row_index, o_mismatches, o_changed, o_last
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// A cell write updates the table memory in the back end. An update or recompute
// reads row 0 when it starts and then steps through the rows in use one by one,
// through the single read port of the row-wide table memory.
// A two-entry queue lets requests arrive while a run is still reporting.
// Reset clears variable values and row counts, sets the configuration to full size;
// table cells are undefined until written. A stalled result holds the run in place.
`default_nettype none
module table_row_mismatch_counter (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_valid,
    output logic                         o_ready,
    input  wire  [trmc_pkg::OP_W-1:0]    i_op,
    input  wire  [trmc_pkg::ROW_W-1:0]   i_row,
    input  wire  [trmc_pkg::COL_W-1:0]   i_col,
    input  wire  [trmc_pkg::VAL_W-1:0]   i_value,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [trmc_pkg::ROW_W-1:0]   o_row_index,
    output logic [trmc_pkg::MIS_W-1:0]   o_mismatches,
    output logic                         o_changed,
    output logic                         o_last,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire                          i_cfg_index,
    input  wire  [trmc_pkg::CFG_D_W-1:0] i_cfg_data
);
    import trmc_pkg::*;

    logic [CFG_R_W-1:0] r_rows_in_use;
    logic [CFG_C_W-1:0] r_cols_in_use;
    logic               q_valid;
    logic               q_ready;
    t_item              q_item;

    assign o_cfg_ready = 1'b1;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use <= CFG_R_W'(ROWS);
            r_cols_in_use <= CFG_C_W'(COLS);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROWS: r_rows_in_use <= CFG_R_W'(i_cfg_data);
                CFG_COLS: r_cols_in_use <= CFG_C_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    trmc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_op      (i_op),
        .i_row     (i_row),
        .i_col     (i_col),
        .i_value   (i_value),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q_item  (q_item)
    );

    trmc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_rows_in_use (r_rows_in_use),
        .i_cols_in_use (r_cols_in_use),
        .i_q_valid     (q_valid),
        .o_q_ready     (q_ready),
        .i_q_item      (q_item),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_row_index   (o_row_index),
        .o_mismatches  (o_mismatches),
        .o_changed     (o_changed),
        .o_last        (o_last)
    );

endmodule
`default_nettype wire

// ===== design/trmc_front.sv =====
// Front end: accepts requests, drops unused ops, queues the rest for the back end.
`default_nettype none
module trmc_front (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_valid,
    output logic                       o_ready,
    input  wire  [trmc_pkg::OP_W-1:0]  i_op,
    input  wire  [trmc_pkg::ROW_W-1:0] i_row,
    input  wire  [trmc_pkg::COL_W-1:0] i_col,
    input  wire  [trmc_pkg::VAL_W-1:0] i_value,
    output logic                       o_q_valid,
    input  wire                        i_q_ready,
    output trmc_pkg::t_item            o_q_item
);
    import trmc_pkg::*;

    t_item              r_q [QDEPTH];
    logic [QPTR_W-1:0]  r_wp;
    logic [QPTR_W-1:0]  r_rp;
    logic [QCNT_W-1:0]  r_cnt;
    logic               push;
    logic               pop;

    // Accept while the queue has room; unused ops are taken and dropped
    assign o_ready   = (r_cnt != QCNT_W'(QDEPTH));
    assign push      = i_valid && o_ready && (i_op != OP_NONE);
    assign o_q_valid = (r_cnt != '0);
    assign pop       = o_q_valid && i_q_ready;
    assign o_q_item  = r_q[r_rp];

    // Advance queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == QPTR_W'(QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == QPTR_W'(QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Store the request payload
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{op: i_op, row: i_row, col: i_col, value: i_value};
        end
    end

endmodule
`default_nettype wire

// ===== design/trmc_back.sv =====
// Back end: table memory, variable values, row counts and the result sequencer.
`default_nettype none
module trmc_back (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire  [trmc_pkg::CFG_R_W-1:0] i_rows_in_use,
    input  wire  [trmc_pkg::CFG_C_W-1:0] i_cols_in_use,
    input  wire                          i_q_valid,
    output logic                         o_q_ready,
    input  trmc_pkg::t_item              i_q_item,
    output logic                         o_valid,
    input  wire                          i_ready,
    output logic [trmc_pkg::ROW_W-1:0]   o_row_index,
    output logic [trmc_pkg::MIS_W-1:0]   o_mismatches,
    output logic                         o_changed,
    output logic                         o_last
);
    import trmc_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // Table memory: one word per row, one lane per column
    logic [COLS*VALUE_WIDTH-1:0] mem [ROWS];
    logic [COLS*VALUE_WIDTH-1:0] r_rd_data;

    logic [VALUE_WIDTH-1:0] r_cur [COLS];
    logic [CNT_W-1:0]       r_cnt [ROWS];

    logic                   r_state;
    logic [ROW_IW-1:0]      r_row;
    logic                   r_recomp;
    logic                   r_upd;
    logic [COL_IW-1:0]      r_col;
    logic [VALUE_WIDTH-1:0] r_old;
    logic [VALUE_WIDTH-1:0] r_new;

    logic                   r_out_valid;
    logic [ROW_W-1:0]       r_out_row;
    logic [MIS_W-1:0]       r_out_mis;
    logic                   r_out_chg;
    logic                   r_out_last;

    logic [NR_W-1:0]        nr;
    logic [CNT_W-1:0]       nc;
    logic                   start;
    logic                   in_range;
    logic [COL_IW-1:0]      q_col;
    logic [VALUE_WIDTH-1:0] q_val;
    logic                   adv;
    logic                   is_last;
    logic                   rd_en;
    logic [ROW_IW-1:0]      rd_addr;
    logic [VALUE_WIDTH-1:0] cell_val;
    logic [CNT_W-1:0]       cnt;
    logic [CNT_W-1:0]       n_cnt;
    logic [CNT_W-1:0]       hits;

    // Clamp the configured sizes to between 1 and the table size
    always_comb begin
        if (i_rows_in_use == '0) begin
            nr = NR_W'(1);
        end else if (int'(i_rows_in_use) > ROWS) begin
            nr = NR_W'(ROWS);
        end else begin
            nr = NR_W'(i_rows_in_use);
        end
        if (i_cols_in_use == '0) begin
            nc = CNT_W'(1);
        end else if (int'(i_cols_in_use) > COLS) begin
            nc = CNT_W'(COLS);
        end else begin
            nc = CNT_W'(i_cols_in_use);
        end
    end

    // Take a request only between runs
    assign o_q_ready = (r_state == ST_IDLE);
    assign start     = i_q_valid && o_q_ready;
    assign in_range  = (int'(i_q_item.col) < COLS);
    assign q_col     = COL_IW'(i_q_item.col);
    assign q_val     = VALUE_WIDTH'(i_q_item.value);

    // Step to the next row when the result slot is free
    assign adv     = (r_state == ST_RUN) && (!r_out_valid || i_ready);
    assign is_last = ((NR_W'(r_row) + 1'b1) == nr);

    // Read row 0 at the start of an update or recompute, the next row on each step but the last
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (start && (i_q_item.op != OP_WRITE)) begin
            rd_en = 1'b1;
        end else if (adv && !is_last) begin
            rd_en   = 1'b1;
            rd_addr = r_row + 1'b1;
        end
    end

    // Work out the new count of the current row
    always_comb begin
        cell_val = r_rd_data[r_col*VALUE_WIDTH +: VALUE_WIDTH];
        cnt      = r_cnt[r_row];
        hits     = '0;
        n_cnt    = cnt;
        for (int c = 0; c < COLS; c++) begin
            if ((CNT_W'(c) < nc) &&
                (r_rd_data[c*VALUE_WIDTH +: VALUE_WIDTH] == r_cur[c])) begin
                hits = hits + 1'b1;
            end
        end
        if (r_recomp) begin
            n_cnt = nc - hits;
        end else if (r_upd) begin
            if (cell_val == r_old) begin
                if (cnt < nc) begin
                    n_cnt = cnt + 1'b1;
                end
            end else if (cell_val == r_new) begin
                if (cnt != '0) begin
                    n_cnt = cnt - 1'b1;
                end
            end
        end
    end

    // Sequencer, variable values and row counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            for (int c = 0; c < COLS; c++) begin
                r_cur[c] <= '0;
            end
            for (int r = 0; r < ROWS; r++) begin
                r_cnt[r] <= '0;
            end
        end else begin
            if (start && (i_q_item.op != OP_WRITE)) begin
                r_state <= ST_RUN;
                if ((i_q_item.op == OP_SET) && in_range) begin
                    r_cur[q_col] <= q_val;
                end
            end else if (adv) begin
                r_cnt[r_row] <= n_cnt;
                if (is_last) begin
                    r_state <= ST_IDLE;
                end
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Latch run parameters and result payload
    always_ff @(posedge i_clk) begin
        if (start) begin
            r_row    <= '0;
            r_recomp <= (i_q_item.op == OP_RECOMP);
            r_col    <= q_col;
            r_old    <= r_cur[q_col];
            r_new    <= q_val;
            r_upd    <= (i_q_item.op == OP_SET) && in_range &&
                        (CNT_W'(i_q_item.col) < nc) && (r_cur[q_col] != q_val);
        end else if (adv) begin
            r_row <= r_row + 1'b1;
        end
        if (adv) begin
            r_out_row  <= ROW_W'(r_row);
            r_out_mis  <= MIS_W'(n_cnt);
            r_out_chg  <= (n_cnt != cnt);
            r_out_last <= is_last;
        end
    end

    // Table memory write and registered read
    always_ff @(posedge i_clk) begin
        if (start && (i_q_item.op == OP_WRITE) && in_range &&
            (int'(i_q_item.row) < ROWS)) begin
            mem[ROW_IW'(i_q_item.row)][q_col*VALUE_WIDTH +: VALUE_WIDTH] <= q_val;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_valid      = r_out_valid;
    assign o_row_index  = r_out_row;
    assign o_mismatches = r_out_mis;
    assign o_changed    = r_out_chg;
    assign o_last       = r_out_last;

endmodule
`default_nettype wire
